FILE: src/wvrs_pkg.sv
package wvrs_pkg;

  // Field widths
  localparam int DIM_W   = 13;
  localparam int POS_W   = 12;
  localparam int COORD_W = 16;

  // Largest layer dimension accepted; larger writes are clamped to it
  localparam int MAX_DIM = 4096;

  // Remainder steps: one per bit of the requested left/top
  localparam int DIV_STEPS = COORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic {
    CMD_SET   = 1'b0,
    CMD_PLACE = 1'b1
  } cmd_e;

  typedef enum logic {
    STS_OK  = 1'b0,
    STS_ERR = 1'b1
  } status_e;

  typedef enum logic [1:0] {
    REG_LAYER_W  = 2'd0,
    REG_LAYER_H  = 2'd1,
    REG_SCREEN_W = 2'd2,
    REG_SCREEN_H = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    PC_MAIN   = 2'd0,
    PC_RIGHT  = 2'd1,
    PC_BOTTOM = 2'd2,
    PC_CORNER = 2'd3
  } piece_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [COORD_W-1:0]   view_left;
    logic [COORD_W-1:0]   view_top;
    logic [DIM_W-1:0]     view_w;
    logic [DIM_W-1:0]     view_h;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [POS_W-1:0]     src_x;
    logic [POS_W-1:0]     src_y;
    logic [DIM_W-1:0]     piece_w;
    logic [DIM_W-1:0]     piece_h;
    logic [DIM_W-1:0]     dst_x;
    logic [DIM_W-1:0]     dst_y;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    reg_idx_e             index;
    logic [DIM_W-1:0]     value;
  } cfg_item_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     div_step;
    logic     commit;
    logic     out_load;
    logic     out_piece;
    status_e  out_status;
    piece_e   piece;
    logic     last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e  cmd;
    logic  set_err;
    logic  place_err;
    logic  wrap_r;
    logic  wrap_b;
    logic  out_free;
  } dp_stat_t;

endpackage

FILE: src/wvrs_chan_if.sv
interface wvrs_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/wrapped_view_rect_split_unit.sv
// Channel | Dir | Payload    | Notes
// in_i    | in  | in_item_t  | set view (cmd 0) or place view (cmd 1)
// out_o   | out | out_item_t | one status item, or one to four pieces, last on final
// cfg_i   | in  | cfg_item_t | register index and value, always ready
//
// Set view: accept, check, 16 remainder steps of the two-lane divider, commit
// and response load, plus any wait on out_o (a size error skips the steps and
// commit); the next item can be taken in the cycle after the load.
// Place: after the check, one piece per cycle while out_o takes them;
// a size error gives one status item instead.
// Reset clears the sequencer and the output valid, and returns the stored view
// and config to their defaults.
// in_i takes a new item once the last result is loaded into the output
// register, even while that result still waits on out_o.
module wrapped_view_rect_split_unit
  import wvrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  wvrs_chan_if.sink   in_i,
  wvrs_chan_if.source out_o,
  wvrs_chan_if.sink   cfg_i
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;
  logic      in_ready;

  // Config writes are taken in any cycle
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  wvrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  wvrs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .in_data_i   (in_i.data),
    .cfg_write_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

endmodule

FILE: src/wvrs_ctrl.sv
module wvrs_ctrl
  import wvrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_stat_t   stat_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_COMMIT,
    ST_RESP,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  piece_e            piece_q, piece_d;
  status_e           resp_q, resp_d;

  piece_e            nxt_piece;
  logic              has_next;

  // Next present piece after the current one
  always_comb begin
    nxt_piece = PC_MAIN;
    has_next  = 1'b0;
    case (piece_q)
      PC_MAIN: begin
        if (stat_i.wrap_r) begin
          nxt_piece = PC_RIGHT;
          has_next  = 1'b1;
        end else if (stat_i.wrap_b) begin
          nxt_piece = PC_BOTTOM;
          has_next  = 1'b1;
        end
      end
      PC_RIGHT: begin
        if (stat_i.wrap_b) begin
          nxt_piece = PC_BOTTOM;
          has_next  = 1'b1;
        end
      end
      PC_BOTTOM: begin
        if (stat_i.wrap_r && stat_i.wrap_b) begin
          nxt_piece = PC_CORNER;
          has_next  = 1'b1;
        end
      end
      default: begin
        has_next = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    piece_d    = piece_q;
    resp_d     = resp_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.cmd == CMD_SET) begin
          if (stat_i.set_err) begin
            resp_d  = STS_ERR;
            state_d = ST_RESP;
          end else begin
            cnt_d   = '0;
            state_d = ST_DIV;
          end
        end else begin
          if (stat_i.place_err) begin
            resp_d  = STS_ERR;
            state_d = ST_RESP;
          end else begin
            piece_d = PC_MAIN;
            state_d = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        resp_d       = STS_OK;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = resp_q;
          cmd_o.last       = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_piece  = 1'b1;
          cmd_o.out_status = STS_OK;
          cmd_o.piece      = piece_q;
          cmd_o.last       = !has_next;
          if (has_next) begin
            piece_d = nxt_piece;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      piece_q <= PC_MAIN;
      resp_q  <= STS_OK;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      piece_q <= piece_d;
      resp_q  <= resp_d;
    end
  end

endmodule

FILE: src/wvrs_dp.sv
module wvrs_dp
  import wvrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_stat_t   stat_o,
  input  in_item_t   in_data_i,
  input  logic       cfg_write_i,
  input  cfg_item_t  cfg_data_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output out_item_t  out_data_o
);

  // Zero reads as one, anything above the limit as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration
  logic [DIM_W-1:0] lw_q, lh_q, sw_q, sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= clamp_dim(DIM_W'(4096));
      lh_q <= clamp_dim(DIM_W'(4096));
      sw_q <= DIM_W'(320);
      sh_q <= DIM_W'(256);
    end else if (cfg_write_i) begin
      unique case (cfg_data_i.index)
        REG_LAYER_W:  lw_q <= clamp_dim(cfg_data_i.value);
        REG_LAYER_H:  lh_q <= clamp_dim(cfg_data_i.value);
        REG_SCREEN_W: sw_q <= cfg_data_i.value;
        REG_SCREEN_H: sh_q <= cfg_data_i.value;
        default: ;
      endcase
    end
  end

  // Latched item and remainder lanes
  cmd_e               cmd_q;
  logic [DIM_W-1:0]   vw_q, vh_q;
  logic [POS_W-1:0]   px_q, py_q;
  logic [COORD_W-1:0] dvd_l_q, dvd_t_q;
  logic [POS_W-1:0]   rem_l_q, rem_t_q;

  logic [DIM_W-1:0]   trial_l, trial_t;
  logic [POS_W-1:0]   rem_l_d, rem_t_d;

  // One restoring remainder step per lane
  always_comb begin
    trial_l = {rem_l_q, dvd_l_q[COORD_W-1]};
    trial_t = {rem_t_q, dvd_t_q[COORD_W-1]};
    rem_l_d = (trial_l >= lw_q) ? POS_W'(trial_l - lw_q) : trial_l[POS_W-1:0];
    rem_t_d = (trial_t >= lh_q) ? POS_W'(trial_t - lh_q) : trial_t[POS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q   <= in_data_i.cmd;
      vw_q    <= in_data_i.view_w;
      vh_q    <= in_data_i.view_h;
      px_q    <= in_data_i.pos_x;
      py_q    <= in_data_i.pos_y;
      dvd_l_q <= in_data_i.view_left;
      dvd_t_q <= in_data_i.view_top;
      rem_l_q <= '0;
      rem_t_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_l_q <= {dvd_l_q[COORD_W-2:0], 1'b0};
      dvd_t_q <= {dvd_t_q[COORD_W-2:0], 1'b0};
      rem_l_q <= rem_l_d;
      rem_t_q <= rem_t_d;
    end
  end

  // Stored view split
  logic [POS_W-1:0] left_q, top_q;
  logic [DIM_W-1:0] main_w_q, main_h_q, wrap_w_q, wrap_h_q;
  logic             wrap_r_q, wrap_b_q;

  logic [DIM_W:0]   sum_l, sum_t;
  logic             wr, wb;

  always_comb begin
    sum_l = (DIM_W+1)'(rem_l_q) + (DIM_W+1)'(vw_q);
    sum_t = (DIM_W+1)'(rem_t_q) + (DIM_W+1)'(vh_q);
    wr    = sum_l > (DIM_W+1)'(lw_q);
    wb    = sum_t > (DIM_W+1)'(lh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      main_w_q <= DIM_W'(MAX_DIM);
      main_h_q <= DIM_W'(MAX_DIM);
      wrap_w_q <= '0;
      wrap_h_q <= '0;
      wrap_r_q <= 1'b0;
      wrap_b_q <= 1'b0;
    end else if (cmd_i.commit) begin
      left_q   <= rem_l_q;
      top_q    <= rem_t_q;
      wrap_r_q <= wr;
      wrap_b_q <= wb;
      main_w_q <= wr ? lw_q - DIM_W'(rem_l_q) : vw_q;
      main_h_q <= wb ? lh_q - DIM_W'(rem_t_q) : vh_q;
      wrap_w_q <= wr ? DIM_W'(sum_l - (DIM_W+1)'(lw_q)) : '0;
      wrap_h_q <= wb ? DIM_W'(sum_t - (DIM_W+1)'(lh_q)) : '0;
    end
  end

  // Size checks
  logic [DIM_W:0] end_x, end_y;

  always_comb begin
    end_x = (DIM_W+1)'(main_w_q) + (DIM_W+1)'(px_q);
    end_y = (DIM_W+1)'(main_h_q) + (DIM_W+1)'(py_q);
  end

  // Piece geometry
  out_item_t       piece;
  logic [DIM_W-1:0] dx_wrap, dy_wrap;

  always_comb begin
    dx_wrap       = DIM_W'(px_q) + main_w_q;
    dy_wrap       = DIM_W'(py_q) + main_h_q;
    piece         = '0;
    piece.status  = STS_OK;
    piece.last    = cmd_i.last;
    case (cmd_i.piece)
      PC_MAIN: begin
        piece.src_x   = left_q;
        piece.src_y   = top_q;
        piece.piece_w = main_w_q;
        piece.piece_h = main_h_q;
        piece.dst_x   = DIM_W'(px_q);
        piece.dst_y   = DIM_W'(py_q);
      end
      PC_RIGHT: begin
        piece.src_y   = top_q;
        piece.piece_w = wrap_w_q;
        piece.piece_h = main_h_q;
        piece.dst_x   = dx_wrap;
        piece.dst_y   = DIM_W'(py_q);
      end
      PC_BOTTOM: begin
        piece.src_x   = left_q;
        piece.piece_w = main_w_q;
        piece.piece_h = wrap_h_q;
        piece.dst_x   = DIM_W'(px_q);
        piece.dst_y   = dy_wrap;
      end
      default: begin
        piece.piece_w = wrap_w_q;
        piece.piece_h = wrap_h_q;
        piece.dst_x   = dx_wrap;
        piece.dst_y   = dy_wrap;
      end
    endcase
  end

  // Status-only result: every field zero but status and last
  out_item_t resp_item;

  always_comb begin
    resp_item        = '0;
    resp_item.status = cmd_i.out_status;
    resp_item.last   = 1'b1;
  end

  // Output register
  logic      out_valid_q;
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= cmd_i.out_piece ? piece : resp_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Status to controller
  always_comb begin
    stat_o.cmd       = cmd_q;
    stat_o.set_err   = (vw_q > lw_q) || (vh_q > lh_q);
    stat_o.place_err = ((DIM_W+1)'(sw_q) < end_x) || ((DIM_W+1)'(sh_q) < end_y);
    stat_o.wrap_r    = wrap_r_q;
    stat_o.wrap_b    = wrap_b_q;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

FILE: tb/tb_wrapped_view_rect_split_unit.sv
`timescale 1ns / 1ps

module tb_wrapped_view_rect_split_unit
  import wvrs_pkg::*;
();

  localparam int CLK_PERIOD  = 4;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_ITEMS  = 500;

  // Predicts the copy pieces of each accepted item and checks them in order
  class split_board;
    int unsigned layer_w, layer_h, screen_w, screen_h;
    int unsigned org_x, org_y, span_w, span_h, wrap_w, wrap_h;
    bit wrap_r, wrap_b;
    out_item_t pending_pieces[$];
    int unsigned bad_count;

    function new();
      layer_w  = MAX_DIM;
      layer_h  = MAX_DIM;
      screen_w = 320;
      screen_h = 256;
      org_x    = 0;
      org_y    = 0;
      span_w   = MAX_DIM;
      span_h   = MAX_DIM;
      wrap_w   = 0;
      wrap_h   = 0;
      wrap_r   = 1'b0;
      wrap_b   = 1'b0;
      bad_count = 0;
    endfunction

    // Layer sizes saturate to 1..MAX_DIM, screen sizes are taken as written
    function int unsigned clamp_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void write_reg(reg_idx_e idx, logic [DIM_W-1:0] val);
      case (idx)
        REG_LAYER_W:  layer_w  = clamp_dim(val);
        REG_LAYER_H:  layer_h  = clamp_dim(val);
        REG_SCREEN_W: screen_w = val;
        REG_SCREEN_H: screen_h = val;
        default: ;
      endcase
    endfunction

    function int unsigned main_width();
      return span_w - wrap_w;
    endfunction

    function int unsigned main_height();
      return span_h - wrap_h;
    endfunction

    function void push_piece(status_e sts, int unsigned sx, int unsigned sy,
                             int unsigned w, int unsigned h, int unsigned dx,
                             int unsigned dy, bit fin);
      out_item_t p;
      p.status  = sts;
      p.src_x   = POS_W'(sx);
      p.src_y   = POS_W'(sy);
      p.piece_w = DIM_W'(w);
      p.piece_h = DIM_W'(h);
      p.dst_x   = DIM_W'(dx);
      p.dst_y   = DIM_W'(dy);
      p.last    = fin;
      pending_pieces.push_back(p);
    endfunction

    function void predict_pieces(in_item_t it);
      int unsigned l, t, mw, mh;
      if (it.cmd == CMD_SET) begin
        // view must fit the layer, otherwise the stored view is kept
        if (it.view_w > layer_w || it.view_h > layer_h) begin
          push_piece(STS_ERR, 0, 0, 0, 0, 0, 0, 1'b1);
          return;
        end
        l = it.view_left % layer_w;
        t = it.view_top % layer_h;
        wrap_r = (l + it.view_w > layer_w);
        wrap_b = (t + it.view_h > layer_h);
        org_x  = l;
        org_y  = t;
        span_w = it.view_w;
        span_h = it.view_h;
        wrap_w = wrap_r ? it.view_w - (layer_w - l) : 0;
        wrap_h = wrap_b ? it.view_h - (layer_h - t) : 0;
        push_piece(STS_OK, 0, 0, 0, 0, 0, 0, 1'b1);
      end else begin
        mw = main_width();
        mh = main_height();
        if (screen_w < mw + it.pos_x || screen_h < mh + it.pos_y) begin
          push_piece(STS_ERR, 0, 0, 0, 0, 0, 0, 1'b1);
          return;
        end
        // main, right wrap, bottom wrap, corner
        push_piece(STS_OK, org_x, org_y, mw, mh, it.pos_x, it.pos_y,
                   !wrap_r && !wrap_b);
        if (wrap_r)
          push_piece(STS_OK, 0, org_y, wrap_w, mh, it.pos_x + mw, it.pos_y, !wrap_b);
        if (wrap_b)
          push_piece(STS_OK, org_x, 0, mw, wrap_h, it.pos_x, it.pos_y + mh, !wrap_r);
        if (wrap_r && wrap_b)
          push_piece(STS_OK, 0, 0, wrap_w, wrap_h, it.pos_x + mw, it.pos_y + mh, 1'b1);
      end
    endfunction

    function void check_piece(out_item_t got);
      out_item_t want;
      if (pending_pieces.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected piece: sts %0d src %0d,%0d size %0dx%0d dst %0d,%0d last %0d",
                   got.status, got.src_x, got.src_y, got.piece_w, got.piece_h,
                   got.dst_x, got.dst_y, got.last);
        return;
      end
      want = pending_pieces.pop_front();
      if (got.status !== want.status || got.src_x !== want.src_x ||
          got.src_y !== want.src_y || got.piece_w !== want.piece_w ||
          got.piece_h !== want.piece_h || got.dst_x !== want.dst_x ||
          got.dst_y !== want.dst_y || got.last !== want.last) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("piece mismatch: expected sts %0d src %0d,%0d size %0dx%0d dst %0d,%0d last %0d",
                   want.status, want.src_x, want.src_y, want.piece_w, want.piece_h,
                   want.dst_x, want.dst_y, want.last);
          $display("                got      sts %0d src %0d,%0d size %0dx%0d dst %0d,%0d last %0d",
                   got.status, got.src_x, got.src_y, got.piece_w, got.piece_h,
                   got.dst_x, got.dst_y, got.last);
        end
      end
    endfunction

    function bit failed();
      return bad_count != 0 || pending_pieces.size() != 0;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  wvrs_chan_if #(.T(in_item_t))  in_ch ();
  wvrs_chan_if #(.T(out_item_t)) out_ch ();
  wvrs_chan_if #(.T(cfg_item_t)) cfg_ch ();

  split_board board = new();

  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;

  wrapped_view_rect_split_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver: stretches of always ready, light stalls and heavy stalls
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(10, 150);
    end
    rx_left--;
    case (rx_mode)
      0:       out_ch.ready = 1'b1;
      1:       out_ch.ready = ($urandom_range(0, 3) != 0);
      default: out_ch.ready = ($urandom_range(0, 7) == 0);
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_piece(out_ch.data);
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("wrapped_view_rect_split_unit test failed");
    $finish;
  end

  function automatic int unsigned min_u(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic in_item_t make_view_item(cmd_e c, int unsigned vl, int unsigned vt,
                                              int unsigned vw, int unsigned vh,
                                              int unsigned px, int unsigned py);
    in_item_t it;
    it.cmd       = c;
    it.view_left = COORD_W'(vl);
    it.view_top  = COORD_W'(vt);
    it.view_w    = DIM_W'(vw);
    it.view_h    = DIM_W'(vh);
    it.pos_x     = POS_W'(px);
    it.pos_y     = POS_W'(py);
    return it;
  endfunction

  // Register size: extremes, out-of-range codes, small and mid values
  function automatic int unsigned pick_size();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return MAX_DIM;
      3:       return $urandom_range(MAX_DIM + 1, 8191);
      4, 5:    return $urandom_range(1, 64);
      default: return $urandom_range(1, MAX_DIM);
    endcase
  endfunction

  // Drive one item and hold it until accepted; valid stays high afterwards
  task automatic send_item(in_item_t it);
    in_ch.data  = it;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.predict_pieces(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Sender works in bursts with random gaps in between
  task automatic offer_item(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 3);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_item(it);
  endtask

  // Hold off until every expected piece has come out
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (board.pending_pieces.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, int unsigned val);
    wait_drained();
    cfg_ch.data  = cfg_item_t'{idx, DIM_W'(val)};
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.write_reg(idx, DIM_W'(val));
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin
    int unsigned vw, vh, mw, mh, px, py, seq_goal, rand_start;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Place before any set: full-layer view cannot fit the screen
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 0, 0));
    offer_item(make_view_item(CMD_SET, 0, 0, 320, 256, 0, 0));
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 0, 0));
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 1, 0));
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 0, 1));
    // View too large, state must survive
    offer_item(make_view_item(CMD_SET, 5, 5, 4097, 1, 0, 0));
    offer_item(make_view_item(CMD_SET, 5, 5, 1, 8191, 0, 0));
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 0, 0));

    write_reg(REG_LAYER_W, 1000);
    write_reg(REG_LAYER_H, 600);
    write_reg(REG_SCREEN_W, 8191);
    write_reg(REG_SCREEN_H, 8191);
    // Wrap both ways, then extreme origins and positions
    offer_item(make_view_item(CMD_SET, 900, 500, 300, 200, 0, 0));
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 100, 100));
    offer_item(make_view_item(CMD_SET, 65535, 65535, 1000, 600, 0, 0));
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 4095, 4095));
    // Exact fit at the edges: no wrap
    offer_item(make_view_item(CMD_SET, 1999, 0, 1, 600, 0, 0));
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 7, 7));
    // Right wrap only, bottom wrap only, empty view
    offer_item(make_view_item(CMD_SET, 999, 0, 2, 10, 0, 0));
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 3, 4));
    offer_item(make_view_item(CMD_SET, 0, 599, 10, 2, 0, 0));
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 4, 3));
    offer_item(make_view_item(CMD_SET, 0, 0, 0, 0, 0, 0));
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 4095, 4095));

    // Layer resized after set keeps the stored split; zero and oversize clamp
    offer_item(make_view_item(CMD_SET, 900, 500, 300, 200, 0, 0));
    write_reg(REG_LAYER_W, 0);
    write_reg(REG_LAYER_H, 8191);
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 0, 0));
    offer_item(make_view_item(CMD_SET, 65535, 65535, 1, 1, 0, 0));
    offer_item(make_view_item(CMD_SET, 0, 0, 2, 1, 0, 0));
    write_reg(REG_SCREEN_W, 0);
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 0, 0));
    write_reg(REG_LAYER_W, 8191);
    write_reg(REG_SCREEN_W, 8191);
    offer_item(make_view_item(CMD_SET, 4095, 4095, 4096, 4096, 0, 0));
    offer_item(make_view_item(CMD_PLACE, 0, 0, 0, 0, 0, 0));

    // Random phases: new registers, then set/place sequences with some noise
    rand_start = items_sent;
    while (items_sent - rand_start < RAND_ITEMS) begin
      write_reg(REG_LAYER_W, pick_size());
      write_reg(REG_LAYER_H, pick_size());
      write_reg(REG_SCREEN_W, pick_size());
      write_reg(REG_SCREEN_H, pick_size());
      seq_goal = items_sent + $urandom_range(30, 70);
      while (items_sent < seq_goal) begin
        if ($urandom_range(0, 9) == 0) begin
          offer_item(make_view_item(cmd_e'($urandom_range(0, 1)),
                                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                                    $urandom_range(0, 8191), $urandom_range(0, 8191),
                                    $urandom_range(0, 4095), $urandom_range(0, 4095)));
        end else begin
          case ($urandom_range(0, 9))
            0: begin
              vw = $urandom_range(0, 8191);
              vh = $urandom_range(0, 8191);
            end
            1: begin
              vw = board.layer_w;
              vh = board.layer_h;
            end
            default: begin
              vw = $urandom_range(0, min_u(board.layer_w, board.screen_w));
              vh = $urandom_range(0, min_u(board.layer_h, board.screen_h));
            end
          endcase
          offer_item(make_view_item(CMD_SET, $urandom_range(0, 65535),
                                    $urandom_range(0, 65535), vw, vh, 0, 0));
          repeat ($urandom_range(1, 3)) begin
            mw = board.main_width();
            mh = board.main_height();
            if ($urandom_range(0, 4) != 0 && board.screen_w >= mw &&
                board.screen_h >= mh) begin
              px = $urandom_range(0, min_u(board.screen_w - mw, 4095));
              py = $urandom_range(0, min_u(board.screen_h - mh, 4095));
            end else begin
              px = $urandom_range(0, 4095);
              py = $urandom_range(0, 4095);
            end
            offer_item(make_view_item(CMD_PLACE, $urandom_range(0, 65535),
                                      $urandom_range(0, 65535), $urandom_range(0, 8191),
                                      $urandom_range(0, 8191), px, py));
          end
        end
        if ($urandom_range(0, 19) == 0)
          wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (!board.failed())
      $display("wrapped_view_rect_split_unit test passed");
    else
      $display("wrapped_view_rect_split_unit test failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/wvrs_pkg.sv
src/wvrs_chan_if.sv
src/wvrs_ctrl.sv
src/wvrs_dp.sv
src/wrapped_view_rect_split_unit.sv
tb/tb_wrapped_view_rect_split_unit.sv
